[rtl/core/vag_pkg.sv]
`timescale 1ns / 1ps

package vag_pkg;

    localparam int LEVEL_W   = 15;
    localparam int STAMP_W   = 32;
    localparam int LEN_W     = 16;
    localparam int MARGIN_W  = 16;
    localparam int CACHE_W   = 32;
    localparam int OUT_T_W   = 34;
    localparam int IN_DATA_W = 64;
    localparam int OUT_DATA_W = 144;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_LEVEL_THRESHOLD = 3'd0,
        CFG_HEAD_MARGIN     = 3'd1,
        CFG_TAIL_MARGIN     = 3'd2,
        CFG_SHORT_CUTOFF    = 3'd3,
        CFG_PASS_ALL        = 3'd4
    } t_cfg_addr;

    localparam logic [LEVEL_W-1:0]  LEVEL_THRESHOLD_RST = 15'd2000;
    localparam logic [MARGIN_W-1:0] HEAD_MARGIN_RST     = 16'd300;
    localparam logic [MARGIN_W-1:0] TAIL_MARGIN_RST     = 16'd350;
    localparam logic [MARGIN_W-1:0] SHORT_CUTOFF_RST    = 16'd150;

    typedef struct packed {
        logic await_init;
        logic await_start;
        logic await_finish;
        logic recording;
    } t_flags;

    localparam t_flags FLAGS_RST = '{await_init: 1'b1, await_start: 1'b1,
                                     await_finish: 1'b0, recording: 1'b0};

    typedef struct packed {
        logic [LEVEL_W-1:0]  level_threshold;
        logic [MARGIN_W-1:0] head_margin;
        logic [MARGIN_W-1:0] tail_margin;
        logic [MARGIN_W-1:0] short_cutoff;
        logic                pass_all;
    } t_cfg;

    typedef struct packed {
        logic [OUT_T_W-1:0] utter_end;
        logic [OUT_T_W-1:0] utter_start;
        logic [OUT_T_W-1:0] out_time;
        logic               flushed_cache;
        logic [CACHE_W-1:0] released_len;
        logic               pass_data;
        logic               done_listening;
        logic               start_listening;
    } t_result;

endpackage

[rtl/core/vag_step.sv]
`timescale 1ns / 1ps

module vag_step
    import vag_pkg::*;
#(
    parameter int TIME_BITS = 34
) (
    input  t_cfg                 i_cfg,
    input  logic [LEVEL_W-1:0]   i_peak_level,
    input  logic [STAMP_W-1:0]   i_chunk_time,
    input  logic [LEN_W-1:0]     i_chunk_len,
    input  logic [LEVEL_W-1:0]   i_prev_peak,
    input  logic [TIME_BITS-1:0] i_time_last_below,
    input  logic [TIME_BITS-1:0] i_time_last_above,
    input  logic [TIME_BITS-1:0] i_start_stamp,
    input  t_flags               i_flags,
    input  logic [CACHE_W-1:0]   i_cached_len,
    output logic [TIME_BITS-1:0] o_time_last_below,
    output logic [TIME_BITS-1:0] o_time_last_above,
    output logic [TIME_BITS-1:0] o_start_stamp,
    output t_flags               o_flags,
    output logic [CACHE_W-1:0]   o_cached_len,
    output t_result              o_result
);

    function automatic logic longer(input logic [TIME_BITS-1:0] a,
                                    input logic [TIME_BITS-1:0] b,
                                    input logic [MARGIN_W-1:0]  limit);
        logic [TIME_BITS-1:0] d;
        d = a - b;
        return !d[TIME_BITS-1] && (d > TIME_BITS'(limit));
    endfunction

    function automatic logic [OUT_T_W-1:0] to_out(input logic [TIME_BITS-1:0] v);
        logic signed [TIME_BITS-1:0] sv;
        logic signed [63:0]          ext;
        sv  = v;
        ext = 64'(sv);
        return ext[OUT_T_W-1:0];
    endfunction

    function automatic logic [CACHE_W-1:0] cache_add(input logic [CACHE_W-1:0] c,
                                                    input logic [LEN_W-1:0]   l);
        logic [CACHE_W:0] s;
        s = {1'b0, c} + (CACHE_W+1)'(l);
        return s[CACHE_W] ? {CACHE_W{1'b1}} : s[CACHE_W-1:0];
    endfunction

    logic [63:0]          time_wide;
    logic [TIME_BITS-1:0] now;
    logic [TIME_BITS-1:0] endt;
    logic [TIME_BITS-1:0] sel_time;
    logic [TIME_BITS-1:0] end_time;
    logic [CACHE_W-1:0]   cache;
    logic                 loud;
    logic                 prev_loud;
    logic                 silent;
    logic                 pass;
    logic                 started;
    logic                 done;
    logic                 flushed;

    assign time_wide = 64'(i_chunk_time);
    assign now       = time_wide[TIME_BITS-1:0];
    assign endt      = now + TIME_BITS'(i_chunk_len);
    assign loud      = i_peak_level > i_cfg.level_threshold;
    assign prev_loud = i_prev_peak > i_cfg.level_threshold;
    assign silent    = longer(endt, i_time_last_above, i_cfg.tail_margin);

    always_comb begin
        o_flags           = i_flags;
        o_start_stamp     = i_start_stamp;
        o_time_last_below = i_time_last_below;
        o_time_last_above = i_time_last_above;
        cache             = i_cached_len;
        pass              = 1'b0;
        started           = 1'b0;
        done              = 1'b0;

        if (loud) begin
            cache = cache_add(cache, i_chunk_len);
            if (prev_loud) begin
                if (i_flags.await_start) begin
                    if (longer(endt, i_time_last_below, i_cfg.short_cutoff)) begin
                        o_flags.await_start  = 1'b0;
                        o_flags.await_finish = 1'b1;
                        if (!i_flags.recording) begin
                            started           = 1'b1;
                            pass              = 1'b1;
                            o_flags.recording = 1'b1;
                        end
                    end
                end else begin
                    pass = 1'b1;
                end
            end else begin
                if (i_flags.await_init) begin
                    o_start_stamp      = i_time_last_below - TIME_BITS'(i_cfg.head_margin);
                    o_flags.await_init = 1'b0;
                end
                if (i_flags.await_finish) begin
                    pass = 1'b1;
                end
            end
            o_time_last_above = endt;
        end else begin
            priority if (i_flags.await_finish) begin
                cache = cache_add(cache, i_chunk_len);
                pass  = 1'b1;
                if (silent) begin
                    done    = 1'b1;
                    o_flags = FLAGS_RST;
                end
            end else if (i_flags.await_init) begin
                cache = cache_add(cache, i_chunk_len);
                if (cache > CACHE_W'(i_cfg.head_margin)) begin
                    cache = CACHE_W'(i_cfg.head_margin);
                end
            end else if (i_flags.await_start) begin
                if (silent) begin
                    o_flags.await_init = 1'b1;
                    if (cache > CACHE_W'(i_cfg.head_margin)) begin
                        cache = CACHE_W'(i_cfg.head_margin);
                    end
                end else begin
                    cache = cache_add(cache, i_chunk_len);
                end
            end else begin
                cache = i_cached_len;
            end
            o_time_last_below = endt;
        end

        // release decision: flush cache on pass or pass-all
        pass     = pass || i_cfg.pass_all;
        flushed  = pass && (cache > CACHE_W'(i_chunk_len));
        sel_time = flushed ? o_start_stamp : now;
        end_time = sel_time + TIME_BITS'(i_chunk_len);

        o_result.start_listening = started;
        o_result.done_listening  = done;
        o_result.pass_data       = pass;
        o_result.released_len    = pass ? cache : '0;
        o_result.flushed_cache   = flushed;
        o_result.out_time        = pass ? to_out(sel_time) : '0;
        o_result.utter_start     = done ? to_out(o_start_stamp) : '0;
        o_result.utter_end       = done ? to_out(end_time) : '0;
        o_cached_len             = pass ? '0 : cache;
    end

endmodule

[rtl/core/voice_activity_gate.sv]
`timescale 1ns / 1ps
// Pipeline: an accepted chunk is held in the input register, then one pass of step logic
// writes the result register; the step waits while the output is stalled.
// Throughput: one chunk per cycle unless the output stalls; the single-pass step logic updates all state.
// Reset (i_rst_n low, synchronous): config and state registers take defaults, detector goes
// back to waiting for sound with an empty cache, and both pipeline stages are emptied.

module voice_activity_gate
    import vag_pkg::*;
#(
    parameter int TIME_BITS = 34
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // peak_level[14:0], chunk_time[46:15], chunk_len[62:47], zero pad
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // start_listening[0], done_listening[1], pass_data[2], released_len[34:3],
    // flushed_cache[35], out_time[69:36], utter_start[103:70], utter_end[137:104], zero pad
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

    t_cfg                 r_cfg;
    logic                 r_in_valid;
    logic [LEVEL_W-1:0]   r_in_peak;
    logic [STAMP_W-1:0]   r_in_time;
    logic [LEN_W-1:0]     r_in_len;
    logic                 r_out_valid;
    t_result              r_result;
    logic [LEVEL_W-1:0]   r_prev_peak;
    logic [TIME_BITS-1:0] r_time_last_below;
    logic [TIME_BITS-1:0] r_time_last_above;
    logic [TIME_BITS-1:0] r_start_stamp;
    t_flags               r_flags;
    logic [CACHE_W-1:0]   r_cached_len;

    logic [TIME_BITS-1:0] n_time_last_below;
    logic [TIME_BITS-1:0] n_time_last_above;
    logic [TIME_BITS-1:0] n_start_stamp;
    t_flags               n_flags;
    logic [CACHE_W-1:0]   n_cached_len;
    t_result              n_result;

    logic in_xfer;
    logic step_go;

    assign step_go         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || step_go;
    assign in_xfer         = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {(OUT_DATA_W - $bits(t_result))'(0), r_result};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.level_threshold <= LEVEL_THRESHOLD_RST;
            r_cfg.head_margin     <= HEAD_MARGIN_RST;
            r_cfg.tail_margin     <= TAIL_MARGIN_RST;
            r_cfg.short_cutoff    <= SHORT_CUTOFF_RST;
            r_cfg.pass_all        <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_LEVEL_THRESHOLD: r_cfg.level_threshold <= i_cfg_wdata[LEVEL_W-1:0];
                CFG_HEAD_MARGIN:     r_cfg.head_margin     <= i_cfg_wdata;
                CFG_TAIL_MARGIN:     r_cfg.tail_margin     <= i_cfg_wdata;
                CFG_SHORT_CUTOFF:    r_cfg.short_cutoff    <= i_cfg_wdata;
                CFG_PASS_ALL:        r_cfg.pass_all        <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (step_go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_peak <= i_s_axis_tdata[14:0];
            r_in_time <= i_s_axis_tdata[46:15];
            r_in_len  <= i_s_axis_tdata[62:47];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step_go) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_go) begin
            r_result <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_peak       <= '0;
            r_time_last_below <= '0;
            r_time_last_above <= '0;
            r_start_stamp     <= '0;
            r_flags           <= FLAGS_RST;
            r_cached_len      <= '0;
        end else if (step_go) begin
            r_prev_peak       <= r_in_peak;
            r_time_last_below <= n_time_last_below;
            r_time_last_above <= n_time_last_above;
            r_start_stamp     <= n_start_stamp;
            r_flags           <= n_flags;
            r_cached_len      <= n_cached_len;
        end
    end

    vag_step #(
        .TIME_BITS(TIME_BITS)
    ) u_step (
        .i_cfg             (r_cfg),
        .i_peak_level      (r_in_peak),
        .i_chunk_time      (r_in_time),
        .i_chunk_len       (r_in_len),
        .i_prev_peak       (r_prev_peak),
        .i_time_last_below (r_time_last_below),
        .i_time_last_above (r_time_last_above),
        .i_start_stamp     (r_start_stamp),
        .i_flags           (r_flags),
        .i_cached_len      (r_cached_len),
        .o_time_last_below (n_time_last_below),
        .o_time_last_above (n_time_last_above),
        .o_start_stamp     (n_start_stamp),
        .o_flags           (n_flags),
        .o_cached_len      (n_cached_len),
        .o_result          (n_result)
    );

    a_rec_matches_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flags.recording == r_flags.await_finish)
        else $error("recording flag out of step with await_finish");

    a_phase_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_flags.await_start && r_flags.await_finish))
        else $error("await_start and await_finish both set");

    a_start_done_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_result.start_listening && r_result.done_listening))
        else $error("utterance started and finished on one chunk");

    a_done_passes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_result.done_listening || r_result.start_listening))
        |-> r_result.pass_data)
        else $error("start or done without release");

    a_cache_empty_after_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step_go && n_result.pass_data) |=> (r_cached_len == '0))
        else $error("cache not emptied after release");

endmodule
